### design/dmcsc_pkg.sv
package dmcsc_pkg;

	typedef enum logic [2:0] {
		KIND_TICK    = 3'd0,
		KIND_CONTROL = 3'd1,
		KIND_LEVEL   = 3'd2,
		KIND_ADDRESS = 3'd3,
		KIND_LENGTH  = 3'd4,
		KIND_ENABLE  = 3'd5
	} kind_t;

	localparam logic [15:0] WRAP_ADDRESS = 16'h8000;
	localparam logic [6:0]  LEVEL_UP_MAX = 7'd125;
	localparam logic [6:0]  LEVEL_DN_MIN = 7'd2;
	localparam logic [3:0]  BYTE_BITS    = 4'd8;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  write_data;
		logic [7:0]  sample_byte;
	} item_t;

	typedef struct packed {
		logic [6:0]  level;
		logic        fetch_valid;
		logic [15:0] fetch_address;
		logic        active;
	} result_t;

	typedef struct packed {
		logic        enabled_flag;
		logic        loop_flag;
		logic [6:0]  out_level;
		logic [15:0] start_address;
		logic [11:0] start_length;
		logic [15:0] fetch_pointer;
		logic [11:0] bytes_left;
		logic [7:0]  shift_bits;
		logic [3:0]  bits_left;
		logic [7:0]  divider_count;
		logic [7:0]  divider_period;
	} chan_state_t;

	function automatic logic [7:0] rate_period(input logic [3:0] idx);
		logic [7:0] p;
		unique case (idx)
			4'd0:  p = 8'd214;
			4'd1:  p = 8'd190;
			4'd2:  p = 8'd170;
			4'd3:  p = 8'd160;
			4'd4:  p = 8'd143;
			4'd5:  p = 8'd127;
			4'd6:  p = 8'd113;
			4'd7:  p = 8'd107;
			4'd8:  p = 8'd95;
			4'd9:  p = 8'd80;
			4'd10: p = 8'd71;
			4'd11: p = 8'd64;
			4'd12: p = 8'd53;
			4'd13: p = 8'd42;
			4'd14: p = 8'd36;
			4'd15: p = 8'd27;
		endcase
		return p;
	endfunction

endpackage

### design/delta_modulation_sample_channel.sv
// An accepted item is held in stage 1, and its result is loaded into the output register
// as soon as that register is free; a full, untaken result register stalls stage 1.
// Throughput: one item per cycle while results are taken; the channel state update in the
// step logic closes on itself combinationally, so items follow back to back.
// Reset (arst_n low, asynchronous): all channel state clears to zero and both
// pipeline stages empty; payload registers are not reset.
module delta_modulation_sample_channel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  dmcsc_pkg::item_t    item,
	output logic                result_valid,
	input  logic                result_ready,
	output dmcsc_pkg::result_t  result
);
	import dmcsc_pkg::*;

	// Stage 1 holds the accepted transaction; stage 2 is the result register.
	item_t       item_s1;
	logic        valid_s1;
	result_t     result_s2;
	logic        valid_s2;

	chan_state_t state_q;
	chan_state_t state_nxt;
	result_t     step_result;

	logic        out_free;
	logic        advance;

	// The result slot frees when empty or when its transaction is taken this cycle.
	assign out_free   = !valid_s2 || result_ready;
	// Advance stage 1 into the result register only when there is room.
	assign advance    = valid_s1 && out_free;
	assign item_ready = !valid_s1 || out_free;

	dmcsc_step u_step (
		.cur    (state_q),
		.item   (item_s1),
		.nxt    (state_nxt),
		.result (step_result)
	);

	// Control: stage valids and the channel state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (item_ready)
				valid_s1 <= item_valid;
			if (out_free)
				valid_s2 <= valid_s1;
			// Commit the channel state only as the transaction leaves stage 1.
			if (advance)
				state_q <= state_nxt;
		end
	end

	// Payload: hold while stalled, load on a free slot.
	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
		if (advance)
			result_s2 <= step_result;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

### design/dmcsc_step.sv
module dmcsc_step (
	input  dmcsc_pkg::chan_state_t cur,
	input  dmcsc_pkg::item_t       item,
	output dmcsc_pkg::chan_state_t nxt,
	output dmcsc_pkg::result_t     result
);
	import dmcsc_pkg::*;

	always_comb begin
		logic        fetch;
		logic [15:0] ptr_inc;
		logic [11:0] bytes_dec;
		logic [7:0]  sb;
		logic [3:0]  bl;

		nxt     = cur;
		fetch   = 1'b0;
		ptr_inc = cur.fetch_pointer + 16'd1;
		bytes_dec = cur.bytes_left - 12'd1;
		sb      = cur.shift_bits;
		bl      = cur.bits_left;

		unique case (item.kind)
			KIND_TICK: begin
				if (cur.enabled_flag) begin
					// load the shifter when it ran dry and bytes remain
					if (cur.bytes_left != 12'd0 && cur.bits_left == 4'd0) begin
						fetch             = 1'b1;
						sb                = item.sample_byte;
						bl                = BYTE_BITS;
						nxt.fetch_pointer = (ptr_inc == 16'd0) ? WRAP_ADDRESS : ptr_inc;
						nxt.bytes_left    = bytes_dec;
						if (bytes_dec == 12'd0 && cur.loop_flag) begin
							nxt.fetch_pointer = cur.start_address;
							nxt.bytes_left    = cur.start_length;
						end
					end
					nxt.shift_bits = sb;
					nxt.bits_left  = bl;
					if (cur.divider_count == 8'd0) begin
						nxt.divider_count = cur.divider_period;
						if (bl != 4'd0) begin
							if (sb[0]) begin
								if (cur.out_level <= LEVEL_UP_MAX)
									nxt.out_level = cur.out_level + 7'd2;
							end else if (cur.out_level >= LEVEL_DN_MIN) begin
								nxt.out_level = cur.out_level - 7'd2;
							end
							nxt.shift_bits = {1'b0, sb[7:1]};
							nxt.bits_left  = bl - 4'd1;
						end
					end else begin
						nxt.divider_count = cur.divider_count - 8'd1;
					end
				end
			end
			KIND_CONTROL: begin
				nxt.loop_flag      = item.write_data[6];
				nxt.divider_period = rate_period(item.write_data[3:0]);
			end
			KIND_LEVEL:   nxt.out_level     = item.write_data[6:0];
			KIND_ADDRESS: nxt.start_address = {2'b11, item.write_data, 6'd0};
			KIND_LENGTH:  nxt.start_length  = {item.write_data, 4'h1};
			KIND_ENABLE: begin
				nxt.enabled_flag = item.write_data[0];
				if (!item.write_data[0]) begin
					nxt.bytes_left = 12'd0;
				end else if (cur.bytes_left == 12'd0) begin
					nxt.fetch_pointer = cur.start_address;
					nxt.bytes_left    = cur.start_length;
				end
			end
			default: ;
		endcase

		result.level         = nxt.out_level;
		result.fetch_valid   = fetch;
		result.fetch_address = fetch ? cur.fetch_pointer : 16'd0;
		result.active        = (nxt.bytes_left != 12'd0);
	end

endmodule

### test/testbench.sv
class dmc_channel_board;
	dmcsc_pkg::chan_state_t chan;
	dmcsc_pkg::result_t     pending_outputs[$];
	logic [7:0]             rate_periods [16];
	int errors        = 0;
	int items_played  = 0;
	int fetches       = 0;
	int wraps         = 0;
	int loop_restarts = 0;
	int clamp_high    = 0;
	int clamp_low     = 0;

	function new();
		chan = '0;
		rate_periods = '{8'd214, 8'd190, 8'd170, 8'd160, 8'd143, 8'd127, 8'd113, 8'd107,
			8'd95, 8'd80, 8'd71, 8'd64, 8'd53, 8'd42, 8'd36, 8'd27};
	endfunction

	function void restart_playback();
		chan.fetch_pointer = chan.start_address;
		chan.bytes_left    = chan.start_length;
	endfunction

	// Advance the channel by one accepted transaction and queue the output it must produce.
	function void play_item(dmcsc_pkg::item_t it);
		dmcsc_pkg::result_t want;
		logic [15:0]        next_ptr;
		want = '0;
		items_played++;
		case (it.kind)
			dmcsc_pkg::KIND_TICK: begin
				if (chan.enabled_flag) begin
					if (chan.bytes_left != 0 && chan.bits_left == 0) begin
						chan.shift_bits    = it.sample_byte;
						chan.bits_left     = dmcsc_pkg::BYTE_BITS;
						want.fetch_valid   = 1'b1;
						want.fetch_address = chan.fetch_pointer;
						fetches++;
						next_ptr = chan.fetch_pointer + 16'd1;
						if (next_ptr == 16'd0) begin
							next_ptr = dmcsc_pkg::WRAP_ADDRESS;
							wraps++;
						end
						chan.fetch_pointer = next_ptr;
						chan.bytes_left    = chan.bytes_left - 12'd1;
						if (chan.bytes_left == 0 && chan.loop_flag) begin
							restart_playback();
							loop_restarts++;
						end
					end
					if (chan.divider_count == 0) begin
						chan.divider_count = chan.divider_period;
						if (chan.bits_left != 0) begin
							if (chan.shift_bits[0]) begin
								if (chan.out_level <= dmcsc_pkg::LEVEL_UP_MAX)
									chan.out_level = chan.out_level + 7'd2;
								else
									clamp_high++;
							end else if (chan.out_level >= dmcsc_pkg::LEVEL_DN_MIN) begin
								chan.out_level = chan.out_level - 7'd2;
							end else begin
								clamp_low++;
							end
							chan.shift_bits = chan.shift_bits >> 1;
							chan.bits_left  = chan.bits_left - 4'd1;
						end
					end else begin
						chan.divider_count = chan.divider_count - 8'd1;
					end
				end
			end
			dmcsc_pkg::KIND_CONTROL: begin
				chan.loop_flag      = it.write_data[6];
				chan.divider_period = rate_periods[it.write_data[3:0]];
			end
			dmcsc_pkg::KIND_LEVEL:   chan.out_level     = it.write_data[6:0];
			dmcsc_pkg::KIND_ADDRESS: chan.start_address = {2'b11, it.write_data, 6'b000000};
			dmcsc_pkg::KIND_LENGTH:  chan.start_length  = {it.write_data, 4'b0001};
			dmcsc_pkg::KIND_ENABLE: begin
				chan.enabled_flag = it.write_data[0];
				if (!it.write_data[0])
					chan.bytes_left = '0;
				else if (chan.bytes_left == 0)
					restart_playback();
			end
			default: ;
		endcase
		want.level  = chan.out_level;
		want.active = (chan.bytes_left != 0);
		pending_outputs.push_back(want);
	endfunction

	function void compare_output(dmcsc_pkg::result_t got);
		dmcsc_pkg::result_t want;
		if (pending_outputs.size() == 0) begin
			$error("output transaction arrived with nothing pending");
			errors++;
			return;
		end
		want = pending_outputs.pop_front();
		if (got.level !== want.level) begin
			$error("level: expected %0d, got %0d", want.level, got.level);
			errors++;
		end
		if (got.fetch_valid !== want.fetch_valid) begin
			$error("fetch_valid: expected %0b, got %0b", want.fetch_valid, got.fetch_valid);
			errors++;
		end
		if (got.fetch_address !== want.fetch_address) begin
			$error("fetch_address: expected %04h, got %04h", want.fetch_address,
				got.fetch_address);
			errors++;
		end
		if (got.active !== want.active) begin
			$error("active: expected %0b, got %0b", want.active, got.active);
			errors++;
		end
	endfunction
endclass

module testbench;
	import dmcsc_pkg::*;

	localparam int CLOCK_PERIOD = 8;
	localparam int CYCLE_LIMIT  = 400000;
	// two-stage pipeline: the quiet drain period after the last result is ample
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1000;

	localparam kind_t      KIND_SPARE_6 = kind_t'(3'd6);
	localparam kind_t      KIND_SPARE_7 = kind_t'(3'd7);
	localparam logic [7:0] CHANNEL_ON   = 8'h01;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	int idle_pct    = 0;
	int stall_pct   = 0;
	int sent_items  = 0;
	int cycle_count = 0;

	dmc_channel_board board = new();

	delta_modulation_sample_channel uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #(CLOCK_PERIOD / 2) clk = ~clk;
	end

	// Bail out if the run hangs; the limit covers the slowest legal run many times over.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outputs still pending", cycle_count,
				board.pending_outputs.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Output side: pick the ready level for the next edge at every falling edge.
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ready = ($urandom_range(99) >= stall_pct);
		end
	end

	// Check every output transaction against the oldest pending expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			board.compare_output(result);
	end

	// Present one input transaction. Call just after a falling edge; returns just after the
	// falling edge that follows acceptance, so back-to-back calls keep valid high.
	task automatic send_item(input kind_t kind, input logic [7:0] data,
			input logic [7:0] sample);
		item_t txn;
		txn.kind        = kind;
		txn.write_data  = data;
		txn.sample_byte = sample;
		// idle the sender for a random stretch before offering the transaction
		while ($urandom_range(99) < idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item       = txn;
		do @(posedge clk); while (!item_ready);
		board.play_item(txn);
		sent_items++;
		@(negedge clk);
	endtask

	// One playback episode: program the channel, enable it, then run ticks with an
	// occasional register write thrown in mid-stream.
	task automatic play_burst();
		logic [7:0] ctrl;
		logic [7:0] lvl;
		logic [7:0] sample;
		int         ticks;
		int         pattern;
		// bias toward the fast rates so bits and bytes actually move within a burst
		ctrl = 8'($urandom);
		if ($urandom_range(3) != 0)
			ctrl[3:0] = 4'($urandom_range(15, 12));
		send_item(KIND_CONTROL, ctrl, 8'($urandom));
		if ($urandom_range(1)) begin
			lvl = 8'($urandom);
			case ($urandom_range(2))
				0: lvl[6:0] = 7'($urandom_range(3));
				1: lvl[6:0] = 7'($urandom_range(127, 124));
				default: ;
			endcase
			send_item(KIND_LEVEL, lvl, 8'($urandom));
		end
		send_item(KIND_ADDRESS, ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom), 8'($urandom));
		// keep most lengths short so looping and end of sample happen often
		send_item(KIND_LENGTH, ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
			8'($urandom));
		send_item(KIND_ENABLE, {7'($urandom), 1'b1}, 8'($urandom));
		ticks   = $urandom_range(150, 20);
		pattern = $urandom_range(2);
		repeat (ticks) begin
			case (pattern)
				0:       sample = 8'hFF;
				1:       sample = 8'h00;
				default: sample = 8'($urandom);
			endcase
			if ($urandom_range(99) < 3)
				send_item(kind_t'($urandom_range(5, 1)), 8'($urandom), 8'($urandom));
			send_item(KIND_TICK, 8'($urandom), sample);
		end
		if ($urandom_range(1))
			send_item(KIND_ENABLE, {7'($urandom), 1'b0}, 8'($urandom));
	endtask

	initial begin
		int phase_start;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: walk the register set and the corner cases from a clean reset.
		send_item(KIND_TICK, 8'h00, 8'hFF);        // tick while disabled: no change
		send_item(KIND_SPARE_6, 8'hFF, 8'hFF);     // unused kinds report state only
		send_item(KIND_SPARE_7, 8'h00, 8'h00);
		send_item(KIND_LEVEL, 8'hFF, 8'h00);       // bit 7 dropped: level 127
		send_item(KIND_CONTROL, 8'hCF, 8'h00);     // interrupt bit ignored, loop, fastest rate
		send_item(KIND_ADDRESS, 8'hFF, 8'h00);     // start 0xFFC0
		send_item(KIND_LENGTH, 8'hFF, 8'h00);      // longest length
		send_item(KIND_ENABLE, CHANNEL_ON, 8'h00); // enable with nothing left: reload
		send_item(KIND_TICK, 8'h00, 8'hFF);        // fetch, level pinned at the top
		send_item(KIND_TICK, 8'hFF, 8'h00);
		send_item(KIND_TICK, 8'h00, 8'h00);
		send_item(KIND_ENABLE, 8'hFF, 8'h00);      // enable while playing: carry on
		send_item(KIND_ENABLE, 8'hFE, 8'hFF);      // disable drops the remaining bytes
		send_item(KIND_TICK, 8'h00, 8'hFF);
		send_item(KIND_LEVEL, 8'h00, 8'h00);
		send_item(KIND_CONTROL, 8'h00, 8'h00);     // no loop, slowest rate
		send_item(KIND_ADDRESS, 8'h00, 8'h00);     // start 0xC000
		send_item(KIND_LENGTH, 8'h00, 8'h00);      // single byte
		send_item(KIND_ENABLE, CHANNEL_ON, 8'h00);
		send_item(KIND_TICK, 8'h00, 8'h00);        // shifter still holds bits: no fetch, stays active
		send_item(KIND_TICK, 8'h00, 8'h00);
		send_item(KIND_CONTROL, 8'h4F, 8'h00);
		send_item(KIND_ENABLE, CHANNEL_ON, 8'h00); // enable again while bytes remain: carry on

		// Random: four idling regimes, each with its share of playback episodes and noise.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 49; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 49; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			phase_start = sent_items;
			while (sent_items - phase_start < RANDOM_ITEMS / 4) begin
				if ($urandom_range(4) != 0)
					play_burst();
				else
					repeat ($urandom_range(5, 1))
						send_item(kind_t'($urandom_range(7)), 8'($urandom), 8'($urandom));
			end
		end

		// Drain: stop offering input, let the pending outputs come home, then hold a while
		// longer so a stray extra output would still be caught.
		item_valid = 1'b0;
		while (board.pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d transactions: %0d byte fetches, %0d address wraps, %0d loop restarts.",
			board.items_played, board.fetches, board.wraps, board.loop_restarts);
		$display("Level held at the ceiling %0d times and at the floor %0d times; %0d errors.",
			board.clamp_high, board.clamp_low, board.errors);
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
